/* design/dtfs_pkg.sv */
// Shared types and constants for the delimited text field splitter.
// No dependencies; imported by delimited_text_field_splitter_top.
package dtfs_pkg;

   localparam int CODE_W   = 16;
   localparam int CMD_W    = 1;
   localparam int KIND_W   = 3;
   localparam int FIELD_W  = 8;
   localparam int COL_W    = 16;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int DCOUNT_W = 2;
   localparam int QCOUNT_W = 2;

   localparam logic [CMD_W-1:0] CMD_CHAR = 1'b0;
   localparam logic [CMD_W-1:0] CMD_EOL  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_CHAR      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_END_FIELD = 3'd1;
   localparam logic [KIND_W-1:0] KIND_END_LINE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ESC_ERR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STRAY     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 3'd5;

   localparam logic [2:0] REG_DELIM_A     = 3'd0;
   localparam logic [2:0] REG_DELIM_B     = 3'd1;
   localparam logic [2:0] REG_DELIM_C     = 3'd2;
   localparam logic [2:0] REG_DELIM_COUNT = 3'd3;
   localparam logic [2:0] REG_QUOTE_A     = 3'd4;
   localparam logic [2:0] REG_QUOTE_B     = 3'd5;
   localparam logic [2:0] REG_QUOTE_COUNT = 3'd6;
   localparam logic [2:0] REG_ESCAPE      = 3'd7;

   localparam logic [CODE_W-1:0]   RST_DELIM_A     = 16'd44;
   localparam logic [CODE_W-1:0]   RST_DELIM_B     = 16'd9;
   localparam logic [CODE_W-1:0]   RST_DELIM_C     = 16'd32;
   localparam logic [DCOUNT_W-1:0] RST_DELIM_COUNT = 2'd1;
   localparam logic [CODE_W-1:0]   RST_QUOTE_A     = 16'd34;
   localparam logic [CODE_W-1:0]   RST_QUOTE_B     = 16'd39;
   localparam logic [QCOUNT_W-1:0] RST_QUOTE_COUNT = 2'd1;
   localparam logic [CODE_W-1:0]   RST_ESCAPE      = 16'd92;

   localparam logic [CODE_W-1:0] CODE_SPACE   = 16'd32;
   localparam logic [CODE_W-1:0] CODE_WS_LOW  = 16'd9;
   localparam logic [CODE_W-1:0] CODE_WS_HIGH = 16'd13;

endpackage

/* design/dtfs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the pending whitespace buffer of the splitter.
module dtfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/delimited_text_field_splitter_top.sv */
// Delimited text field splitter: parse state machine, CSR block and output register.
// Depends on dtfs_pkg and dtfs_ram (pending whitespace buffer).
//
//   channel  direction  handshake             payload
//   req      in         req_valid / req_stall  cmd, code_unit
//   rsp      out        rsp_valid / rsp_stall  kind, char_out, field_index, column, last
//   csr      in/out     psel penable pready    pwrite, paddr, pwdata, prdata
//
// An item with at most one result needs no burst. A character that flushes n pending
// spaces is a burst: the spaces come out of the buffer RAM's single read port one per
// cycle unless the output stalls, then the character. End of line that closes a field
// gives end of field, then end of line. Reset is synchronous; it clears control state
// only, the buffer RAM is not cleared. rsp_stall holds the output register; req_stall
// is high during a burst and while the output register is full and stalled.
module delimited_text_field_splitter_top #(
   parameter int PENDING_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dtfs_pkg::CMD_W-1:0]    req_cmd,
   input  logic [dtfs_pkg::CODE_W-1:0]   req_code_unit,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dtfs_pkg::KIND_W-1:0]   rsp_kind,
   output logic [dtfs_pkg::CODE_W-1:0]   rsp_char_out,
   output logic [dtfs_pkg::FIELD_W-1:0]  rsp_field_index,
   output logic [dtfs_pkg::COL_W-1:0]    rsp_column,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [dtfs_pkg::CSR_AW-1:0]   paddr,
   input  logic [dtfs_pkg::CSR_DW-1:0]   pwdata,
   output logic [dtfs_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   import dtfs_pkg::*;

   localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CW = $clog2(PENDING_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_OUTSIDE,
      MODE_INSIDE,
      MODE_QUOTED,
      MODE_ESCAPED,
      MODE_AFTER_QUOTE
   } mode_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_FLUSH,
      SEQ_CHAR,
      SEQ_EOL
   } seq_type;

   logic [CODE_W-1:0]   delim_a_ff, delim_a_in, delim_b_ff, delim_b_in;
   logic [CODE_W-1:0]   delim_c_ff, delim_c_in;
   logic [DCOUNT_W-1:0] delim_count_ff, delim_count_in;
   logic [CODE_W-1:0]   quote_a_ff, quote_a_in, quote_b_ff, quote_b_in;
   logic [QCOUNT_W-1:0] quote_count_ff, quote_count_in;
   logic [CODE_W-1:0]   escape_ff, escape_in;

   mode_type            mode_ff, mode_in;
   seq_type             seq_ff, seq_in;
   logic [CODE_W-1:0]   open_quote_ff, open_quote_in;
   logic [FIELD_W-1:0]  field_ff, field_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [CW-1:0]       pcnt_ff, pcnt_in;
   logic                has_text_ff, has_text_in;
   logic                failed_ff, failed_in;
   logic [CW-1:0]       flush_cnt_ff, flush_cnt_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic [CODE_W-1:0]   held_char_ff, held_char_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [CODE_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [FIELD_W-1:0]  rsp_field_ff, rsp_field_in;
   logic [COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free, req_fire, csr_write;
   logic [2:0]          csr_index;
   logic [CODE_W-1:0]   c;
   logic                c_space, c_delim, c_quote;
   logic [COL_W-1:0]    col_inc;
   logic [FIELD_W-1:0]  field_inc;
   logic                do_take, do_end;
   logic                emit;
   logic [KIND_W-1:0]   emit_kind;
   logic [CODE_W-1:0]   emit_char;
   logic [FIELD_W-1:0]  emit_field;
   logic [COL_W-1:0]    emit_col;
   logic                emit_last;
   logic                ram_wr_en, ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [CODE_W-1:0]   ram_rd_data;

   dtfs_ram #(
      .WIDTH(CODE_W),
      .DEPTH(PENDING_DEPTH)
   ) u_pending (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(pcnt_ff[AW-1:0]),
      .wr_data(c),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((seq_ff == SEQ_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];
   assign pready    = 1'b1;

   assign c         = req_code_unit;
   assign c_space   = (c == CODE_SPACE) || ((c >= CODE_WS_LOW) && (c <= CODE_WS_HIGH));
   assign c_delim   = ((delim_count_ff >= 2'd1) && (c == delim_a_ff)) ||
                      ((delim_count_ff >= 2'd2) && (c == delim_b_ff)) ||
                      ((delim_count_ff >= 2'd3) && (c == delim_c_ff));
   assign c_quote   = ((quote_count_ff >= 2'd1) && (c == quote_a_ff)) ||
                      ((quote_count_ff >= 2'd2) && (c == quote_b_ff));
   assign col_inc   = (col_ff == '1) ? col_ff : col_ff + COL_W'(1);
   assign field_inc = (field_ff == '1) ? field_ff : field_ff + FIELD_W'(1);

   // csr block
   always_comb begin
      delim_a_in     = delim_a_ff;
      delim_b_in     = delim_b_ff;
      delim_c_in     = delim_c_ff;
      delim_count_in = delim_count_ff;
      quote_a_in     = quote_a_ff;
      quote_b_in     = quote_b_ff;
      quote_count_in = quote_count_ff;
      escape_in      = escape_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DELIM_A:     delim_a_in     = pwdata[CODE_W-1:0];
            REG_DELIM_B:     delim_b_in     = pwdata[CODE_W-1:0];
            REG_DELIM_C:     delim_c_in     = pwdata[CODE_W-1:0];
            REG_DELIM_COUNT: delim_count_in = pwdata[DCOUNT_W-1:0];
            REG_QUOTE_A:     quote_a_in     = pwdata[CODE_W-1:0];
            REG_QUOTE_B:     quote_b_in     = pwdata[CODE_W-1:0];
            REG_QUOTE_COUNT: quote_count_in = pwdata[QCOUNT_W-1:0];
            REG_ESCAPE:      escape_in      = pwdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DELIM_A:     prdata = CSR_DW'(delim_a_ff);
         REG_DELIM_B:     prdata = CSR_DW'(delim_b_ff);
         REG_DELIM_C:     prdata = CSR_DW'(delim_c_ff);
         REG_DELIM_COUNT: prdata = CSR_DW'(delim_count_ff);
         REG_QUOTE_A:     prdata = CSR_DW'(quote_a_ff);
         REG_QUOTE_B:     prdata = CSR_DW'(quote_b_ff);
         REG_QUOTE_COUNT: prdata = CSR_DW'(quote_count_ff);
         REG_ESCAPE:      prdata = CSR_DW'(escape_ff);
         default:         prdata = '0;
      endcase
   end

   // parser and burst sequencer
   always_comb begin
      mode_in       = mode_ff;
      seq_in        = seq_ff;
      open_quote_in = open_quote_ff;
      field_in      = field_ff;
      col_in        = col_ff;
      pcnt_in       = pcnt_ff;
      has_text_in   = has_text_ff;
      failed_in     = failed_ff;
      flush_cnt_in  = flush_cnt_ff;
      rd_idx_in     = rd_idx_ff;
      held_char_in  = held_char_ff;
      do_take       = 1'b0;
      do_end        = 1'b0;
      emit          = 1'b0;
      emit_kind     = KIND_CHAR;
      emit_char     = '0;
      emit_field    = field_ff;
      emit_col      = col_ff;
      emit_last     = 1'b1;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (req_fire && (req_cmd == CMD_EOL)) begin
               if (!failed_ff && has_text_ff && (mode_ff != MODE_AFTER_QUOTE)) begin
                  emit      = 1'b1;
                  emit_kind = KIND_END_FIELD;
                  emit_last = 1'b0;
                  field_in  = field_inc;
                  seq_in    = SEQ_EOL;
               end else begin
                  emit          = 1'b1;
                  emit_kind     = KIND_END_LINE;
                  mode_in       = MODE_OUTSIDE;
                  open_quote_in = '0;
                  field_in      = '0;
                  col_in        = '0;
                  pcnt_in       = '0;
                  has_text_in   = 1'b0;
                  failed_in     = 1'b0;
               end
            end else if (req_fire) begin
               col_in   = col_inc;
               emit_col = col_inc;
               if (!failed_ff) begin
                  unique case (mode_ff)
                     MODE_OUTSIDE: begin
                        if (c_delim) begin
                           do_end = 1'b1;
                        end else if (c_quote) begin
                           mode_in       = MODE_QUOTED;
                           open_quote_in = c;
                        end else begin
                           mode_in = MODE_INSIDE;
                           do_take = 1'b1;
                        end
                     end
                     MODE_INSIDE: begin
                        if (c_delim) begin
                           do_end  = 1'b1;
                           mode_in = MODE_OUTSIDE;
                        end else begin
                           do_take = 1'b1;
                        end
                     end
                     MODE_QUOTED: begin
                        if (c_quote) begin
                           do_end  = 1'b1;
                           mode_in = MODE_AFTER_QUOTE;
                        end else if (c == escape_ff) begin
                           mode_in = MODE_ESCAPED;
                        end else begin
                           do_take = 1'b1;
                        end
                     end
                     MODE_ESCAPED: begin
                        if ((c == escape_ff) || (c == open_quote_ff)) begin
                           do_take = 1'b1;
                           mode_in = MODE_QUOTED;
                        end else begin
                           emit      = 1'b1;
                           emit_kind = KIND_ESC_ERR;
                           emit_char = c;
                           failed_in = 1'b1;
                        end
                     end
                     MODE_AFTER_QUOTE: begin
                        if (c_delim) begin
                           mode_in = MODE_OUTSIDE;
                        end else begin
                           emit      = 1'b1;
                           emit_kind = KIND_STRAY;
                           emit_char = c;
                        end
                     end
                     default: ;
                  endcase
               end
               if (do_end) begin
                  emit        = 1'b1;
                  emit_kind   = KIND_END_FIELD;
                  field_in    = field_inc;
                  pcnt_in     = '0;
                  has_text_in = 1'b0;
               end
               if (do_take) begin
                  if (c_space) begin
                     if (has_text_ff) begin
                        if (pcnt_ff >= CW'(PENDING_DEPTH)) begin
                           emit      = 1'b1;
                           emit_kind = KIND_OVERFLOW;
                           emit_char = c;
                        end else begin
                           ram_wr_en = 1'b1;
                           pcnt_in   = pcnt_ff + CW'(1);
                        end
                     end
                  end else begin
                     has_text_in = 1'b1;
                     pcnt_in     = '0;
                     if (pcnt_ff != '0) begin
                        ram_rd_en    = 1'b1;
                        flush_cnt_in = pcnt_ff;
                        rd_idx_in    = CW'(1);
                        held_char_in = c;
                        seq_in       = SEQ_FLUSH;
                     end else begin
                        emit      = 1'b1;
                        emit_kind = KIND_CHAR;
                        emit_char = c;
                     end
                  end
               end
            end
         end
         SEQ_FLUSH: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = KIND_CHAR;
               emit_char = ram_rd_data;
               emit_last = 1'b0;
               if (rd_idx_ff < flush_cnt_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = rd_idx_ff[AW-1:0];
                  rd_idx_in   = rd_idx_ff + CW'(1);
               end else begin
                  seq_in = SEQ_CHAR;
               end
            end
         end
         SEQ_CHAR: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = KIND_CHAR;
               emit_char = held_char_ff;
               seq_in    = SEQ_IDLE;
            end
         end
         SEQ_EOL: begin
            if (out_free) begin
               emit          = 1'b1;
               emit_kind     = KIND_END_LINE;
               seq_in        = SEQ_IDLE;
               mode_in       = MODE_OUTSIDE;
               open_quote_in = '0;
               field_in      = '0;
               col_in        = '0;
               pcnt_in       = '0;
               has_text_in   = 1'b0;
               failed_in     = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_field_in = rsp_field_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_char_in  = emit_char;
         rsp_field_in = emit_field;
         rsp_col_in   = emit_col;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_a_ff     <= RST_DELIM_A;
         delim_b_ff     <= RST_DELIM_B;
         delim_c_ff     <= RST_DELIM_C;
         delim_count_ff <= RST_DELIM_COUNT;
         quote_a_ff     <= RST_QUOTE_A;
         quote_b_ff     <= RST_QUOTE_B;
         quote_count_ff <= RST_QUOTE_COUNT;
         escape_ff      <= RST_ESCAPE;
         mode_ff        <= MODE_OUTSIDE;
         seq_ff         <= SEQ_IDLE;
         open_quote_ff  <= '0;
         field_ff       <= '0;
         col_ff         <= '0;
         pcnt_ff        <= '0;
         has_text_ff    <= 1'b0;
         failed_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         delim_a_ff     <= delim_a_in;
         delim_b_ff     <= delim_b_in;
         delim_c_ff     <= delim_c_in;
         delim_count_ff <= delim_count_in;
         quote_a_ff     <= quote_a_in;
         quote_b_ff     <= quote_b_in;
         quote_count_ff <= quote_count_in;
         escape_ff      <= escape_in;
         mode_ff        <= mode_in;
         seq_ff         <= seq_in;
         open_quote_ff  <= open_quote_in;
         field_ff       <= field_in;
         col_ff         <= col_in;
         pcnt_ff        <= pcnt_in;
         has_text_ff    <= has_text_in;
         failed_ff      <= failed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      flush_cnt_ff <= flush_cnt_in;
      rd_idx_ff    <= rd_idx_in;
      held_char_ff <= held_char_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_field_ff <= rsp_field_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_field_index = rsp_field_ff;
   assign rsp_column      = rsp_col_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
